@@ rtl/core/rbsc_pkg.sv @@
package rbsc_pkg;

   localparam logic [31:0] K_A = 32'h1111_1111;
   localparam logic [31:0] K_B = 32'h5555_5555;
   localparam logic [31:0] K_C = 32'hAAAA_AAAA;

   localparam logic [31:0] ROT_INIT = K_C ^ 32'h5E50_2382;
   localparam logic [31:0] A_INIT   = K_A ^ 32'h6649_A53A;
   localparam logic [31:0] B_INIT   = K_B ^ 32'h62FD_125B;
   localparam logic [31:0] W1_MASK  = K_A ^ 32'h8AF6_5559;
   localparam logic [31:0] W2_MASK  = K_B ^ 32'h33A1_791D;
   localparam logic [31:0] MIX_MASK = K_C ^ 32'h8CD1_A1BB;
   localparam logic [31:0] T1_AND   = K_A ^ 32'hACFA_66CF;
   localparam logic [31:0] T1_OR    = K_B ^ 32'h5751_5D54;
   localparam logic [31:0] T2_AND   = K_C ^ 32'hD7D4_1174;
   localparam logic [31:0] T2_OR    = K_A ^ 32'h1191_5130;

   localparam logic [31:0] DEFAULT_BASE = B_INIT ^ A_INIT ^ ROT_INIT;

   localparam logic [7:0] POS_MULT = 8'hB9;

   // multiplier digit width, bits per cycle
   localparam int MUL_DIGIT = 4;
   localparam int MUL_STEPS = 32 / MUL_DIGIT;
   localparam int MUL_CNT_W = $clog2(MUL_STEPS);

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_SEED    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_USE_DEFAULT = 1'd1;

   typedef struct packed {
      logic        start;
      logic [31:0] seed;
   } sched_ctl_type;

   typedef struct packed {
      logic        done;
      logic [31:0] key;
   } sched_sts_type;

endpackage

@@ rtl/core/rbsc_req_if.sv @@
interface rbsc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_in;
   logic       last_in;

   modport source (output valid, output data_in, output last_in, input ready);
   modport sink   (input valid, input data_in, input last_in, output ready);
endinterface

@@ rtl/core/rbsc_rsp_if.sv @@
interface rbsc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_out;
   logic       last_out;

   modport source (output valid, output data_out, output last_out, input ready);
   modport sink   (input valid, input data_out, input last_out, output ready);
endinterface

@@ rtl/core/rbsc_sched.sv @@
module rbsc_sched (
   input  logic                    clock,
   input  logic                    reset,
   input  rbsc_pkg::sched_ctl_type ctl,
   output rbsc_pkg::sched_sts_type sts
);

   localparam int D = rbsc_pkg::MUL_DIGIT;
   localparam int CW = rbsc_pkg::MUL_CNT_W;
   localparam logic [CW-1:0] LAST_STEP = CW'(rbsc_pkg::MUL_STEPS - 1);

   localparam logic [2:0] SS_IDLE  = 3'd0;
   localparam logic [2:0] SS_PREP  = 3'd1;
   localparam logic [2:0] SS_LOADT = 3'd2;
   localparam logic [2:0] SS_MUL   = 3'd3;
   localparam logic [2:0] SS_FOLD  = 3'd4;

   logic [2:0]    st_ff, st_in;
   logic [1:0]    round_ff, round_in;
   logic          second_ff, second_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          done_ff, done_in;
   logic [31:0]   rot_ff, rot_in, a_ff, a_in, b_ff, b_in;
   logic [31:0]   s_ff, s_in, w1_ff, w1_in, w2_ff, w2_in;
   logic [31:0]   mix_ff, mix_in, xa_ff, xa_in, xb_ff, xb_in;
   logic [31:0]   t_ff, t_in, x_ff, x_in, key_ff, key_in;
   logic [63:0]   prod_ff, prod_in;

   logic [31:0] w_sel, rot_next, lo, hi, a_fold;
   logic [31+D:0] partial;

   always_comb begin
      case (round_ff)
         2'd1:    w_sel = w1_ff;
         2'd2:    w_sel = w2_ff;
         default: w_sel = s_ff;
      endcase
   end

   assign rot_next = {rot_ff[30:0], rot_ff[31]};
   assign partial  = {{D{1'b0}}, prod_ff[63:32]} + ((32+D)'(t_ff) * (32+D)'(x_ff[D-1:0]));
   assign lo       = prod_ff[31:0];
   assign hi       = prod_ff[63:32];
   assign a_fold   = lo + {hi[30:0], 1'b0};

   always_comb begin
      st_in     = st_ff;
      round_in  = round_ff;
      second_in = second_ff;
      cnt_in    = cnt_ff;
      done_in   = 1'b0;
      rot_in    = rot_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      s_in      = s_ff;
      w1_in     = w1_ff;
      w2_in     = w2_ff;
      mix_in    = mix_ff;
      xa_in     = xa_ff;
      xb_in     = xb_ff;
      t_in      = t_ff;
      x_in      = x_ff;
      key_in    = key_ff;
      prod_in   = prod_ff;
      unique case (st_ff)
         SS_IDLE: begin
            if (ctl.start) begin
               s_in     = ctl.seed;
               w1_in    = ctl.seed ^ rbsc_pkg::W1_MASK;
               w2_in    = ctl.seed ^ rbsc_pkg::W2_MASK;
               rot_in   = rbsc_pkg::ROT_INIT;
               a_in     = rbsc_pkg::A_INIT;
               b_in     = rbsc_pkg::B_INIT;
               round_in = 2'd0;
               st_in    = SS_PREP;
            end
         end
         SS_PREP: begin
            rot_in    = rot_next;
            mix_in    = rbsc_pkg::MIX_MASK ^ rot_next;
            xb_in     = b_ff ^ w_sel;
            xa_in     = a_ff ^ w_sel;
            second_in = 1'b0;
            st_in     = SS_LOADT;
         end
         SS_LOADT: begin
            if (!second_ff) begin
               t_in = ((mix_ff + xa_ff) & rbsc_pkg::T1_AND) | rbsc_pkg::T1_OR;
               x_in = xb_ff;
            end else begin
               t_in = ((mix_ff + xb_ff) & rbsc_pkg::T2_AND) | rbsc_pkg::T2_OR;
               x_in = xa_ff;
            end
            prod_in = '0;
            cnt_in  = '0;
            st_in   = SS_MUL;
         end
         SS_MUL: begin
            prod_in = {partial, prod_ff[31:D]};
            x_in    = x_ff >> D;
            cnt_in  = cnt_ff + CW'(1);
            if (cnt_ff == LAST_STEP) begin
               st_in = SS_FOLD;
            end
         end
         SS_FOLD: begin
            if (!second_ff) begin
               b_in      = hi + lo + {31'b0, hi != 32'd0};
               second_in = 1'b1;
               st_in     = SS_LOADT;
            end else begin
               a_in = a_fold;
               if (round_ff == 2'd3) begin
                  key_in  = b_ff ^ a_fold;
                  done_in = 1'b1;
                  st_in   = SS_IDLE;
               end else begin
                  round_in = round_ff + 2'd1;
                  st_in    = SS_PREP;
               end
            end
         end
         default: st_in = SS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= SS_IDLE;
         done_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         done_ff <= done_in;
      end
      round_ff  <= round_in;
      second_ff <= second_in;
      cnt_ff    <= cnt_in;
      rot_ff    <= rot_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      s_ff      <= s_in;
      w1_ff     <= w1_in;
      w2_ff     <= w2_in;
      mix_ff    <= mix_in;
      xa_ff     <= xa_in;
      xb_ff     <= xb_in;
      t_ff      <= t_in;
      x_ff      <= x_in;
      key_ff    <= key_in;
      prod_ff   <= prod_in;
   end

   assign sts.done = done_ff;
   assign sts.key  = key_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.start |-> st_ff == SS_IDLE)
      else $error("schedule started while busy");

   a_done_from_fold: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(st_ff) == SS_FOLD && $past(round_ff) == 2'd3)
      else $error("schedule done without final fold");

   a_mul_steps: assert property (@(posedge clock) disable iff (reset)
      st_ff == SS_FOLD |-> $past(st_ff) == SS_MUL && $past(cnt_ff) == LAST_STEP)
      else $error("fold before all digits done");

endmodule

@@ rtl/core/rekeying_byte_stream_cipher_core.sv @@
// channel  | dir | payload           | handshake
// req_bus  | in  | data_in, last_in  | valid/ready
// rsp_bus  | out | data_out, last_out| valid/ready
// csr_*    | in  | index, wdata      | csr_we, no wait
//
// Bytes inside a message: one word per cycle while rsp_bus.ready is high, output registered.
// First byte of a message: one key schedule run, two runs when
// the default key is selected; each run is 4 rounds of two 8-step serial multiplies.
// After every 256th byte one schedule run rekeys before the next word is taken.
// Synchronous active-high reset; req_bus.ready drops while a schedule runs, while
// the first word of a message leaves the hold register, and while the output word
// is held by rsp_bus.ready low.
module rekeying_byte_stream_cipher_core (
   input  logic                               clock,
   input  logic                               reset,
   rbsc_req_if.sink                           req_bus,
   rbsc_rsp_if.source                         rsp_bus,
   input  logic                               csr_we,
   input  logic [rbsc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [31:0]                        csr_wdata
);

   localparam logic [2:0] ST_RUN   = 3'd0;
   localparam logic [2:0] ST_DEF   = 3'd1;
   localparam logic [2:0] ST_KEY   = 3'd2;
   localparam logic [2:0] ST_HOLD  = 3'd3;
   localparam logic [2:0] ST_REKEY = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic [31:0] key_seed_ff, key_seed_in;
   logic        use_def_ff, use_def_in;
   logic [31:0] key_word_ff, key_word_in;
   logic [31:0] pos_ff, pos_in;
   logic        in_msg_ff, in_msg_in;
   logic [7:0]  hold_data_ff;
   logic        hold_last_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_data_ff, rsp_data_in;
   logic        rsp_last_ff, rsp_last_in;

   rbsc_pkg::sched_ctl_type sched_ctl;
   rbsc_pkg::sched_sts_type sched_sts;

   logic       space, accept, fire;
   logic [7:0] item_data, kb, pb;
   logic       item_last;

   rbsc_sched u_sched (
      .clock (clock),
      .reset (reset),
      .ctl   (sched_ctl),
      .sts   (sched_sts)
   );

   assign space         = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = (state_ff == ST_RUN) && space;
   assign accept        = req_bus.valid && req_bus.ready;
   assign fire          = (accept && in_msg_ff) || (state_ff == ST_HOLD && space);
   assign item_data     = (state_ff == ST_HOLD) ? hold_data_ff : req_bus.data_in;
   assign item_last     = (state_ff == ST_HOLD) ? hold_last_ff : req_bus.last_in;
   assign pb            = 8'(pos_ff[7:0] * rbsc_pkg::POS_MULT);

   always_comb begin
      case (pos_ff[1:0])
         2'd0:    kb = key_word_ff[7:0];
         2'd1:    kb = key_word_ff[15:8];
         2'd2:    kb = key_word_ff[23:16];
         default: kb = key_word_ff[31:24];
      endcase
   end

   always_comb begin
      key_seed_in = key_seed_ff;
      use_def_in  = use_def_ff;
      if (csr_we) begin
         unique case (csr_index)
            rbsc_pkg::CSR_KEY_SEED:    key_seed_in = csr_wdata;
            rbsc_pkg::CSR_USE_DEFAULT: use_def_in  = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in       = state_ff;
      key_word_in    = key_word_ff;
      pos_in         = pos_ff;
      in_msg_in      = in_msg_ff;
      sched_ctl      = '0;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      rsp_data_in    = rsp_data_ff;
      rsp_last_in    = rsp_last_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = item_data ^ kb ^ pb;
         rsp_last_in  = item_last;
         pos_in       = pos_ff + 32'd1;
         if (item_last) begin
            in_msg_in = 1'b0;
         end
      end
      unique case (state_ff) inside
         ST_RUN, ST_HOLD: begin
            if (accept && !in_msg_ff) begin
               pos_in         = '0;
               in_msg_in      = 1'b1;
               sched_ctl.start = 1'b1;
               sched_ctl.seed  = use_def_ff ? rbsc_pkg::DEFAULT_BASE : key_seed_ff;
               state_in       = use_def_ff ? ST_DEF : ST_KEY;
            end else if (fire) begin
               if (pos_ff[7:0] == 8'hFF) begin
                  sched_ctl.start = 1'b1;
                  sched_ctl.seed  = key_word_ff ^ pos_ff;
                  state_in       = ST_REKEY;
               end else begin
                  state_in = ST_RUN;
               end
            end
         end
         ST_DEF: begin
            if (sched_sts.done) begin
               sched_ctl.start = 1'b1;
               sched_ctl.seed  = sched_sts.key;
               state_in       = ST_KEY;
            end
         end
         ST_KEY: begin
            if (sched_sts.done) begin
               key_word_in = sched_sts.key;
               state_in    = ST_HOLD;
            end
         end
         ST_REKEY: begin
            if (sched_sts.done) begin
               key_word_in = sched_sts.key;
               state_in    = ST_RUN;
            end
         end
         default: state_in = ST_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         key_seed_ff  <= '0;
         use_def_ff   <= 1'b1;
         key_word_ff  <= '0;
         pos_ff       <= '0;
         in_msg_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         key_seed_ff  <= key_seed_in;
         use_def_ff   <= use_def_in;
         key_word_ff  <= key_word_in;
         pos_ff       <= pos_in;
         in_msg_ff    <= in_msg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         hold_data_ff <= req_bus.data_in;
         hold_last_ff <= req_bus.last_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.data_out = rsp_data_ff;
   assign rsp_bus.last_out = rsp_last_ff;

   a_done_when_waiting: assert property (@(posedge clock) disable iff (reset)
      sched_sts.done |-> state_ff == ST_DEF || state_ff == ST_KEY || state_ff == ST_REKEY)
      else $error("schedule result with no one waiting");

   a_pos_step: assert property (@(posedge clock) disable iff (reset)
      fire |=> pos_ff == $past(pos_ff) + 32'd1)
      else $error("byte position did not advance");

   a_rekey_boundary: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_REKEY && $past(state_ff) != ST_REKEY |-> pos_ff[7:0] == 8'h00)
      else $error("rekey off the 256-byte boundary");

endmodule

@@ bench/tb_rekeying_byte_stream_cipher_core.sv @@
module tb_rekeying_byte_stream_cipher_core;
   import rbsc_pkg::*;

   localparam int CYCLE_LIMIT = 500000;

   typedef struct packed {
      logic [7:0] data;
      logic       is_last;
   } cipher_word_type;

   logic clock;
   logic reset = 1'b1;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [31:0]          csr_wdata;

   rbsc_req_if req_bus ();
   rbsc_rsp_if rsp_bus ();

   rekeying_byte_stream_cipher_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow of the cipher state and registers
   logic [31:0] sh_key_seed;
   logic        sh_use_default;
   logic [31:0] sh_key_word;
   logic [31:0] sh_byte_pos;
   logic        sh_in_msg;

   cipher_word_type pending_cipher_words[$];
   int           mismatch_count = 0;
   int           cycle_count = 0;
   int           rsp_hold_len = 0;
   logic         req_idle_en = 1'b0;
   logic         rsp_idle_en = 1'b0;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic logic [31:0] key_schedule(input logic [31:0] s);
      logic [31:0] w [4];
      logic [31:0] rot, a, b, mix, xa, xb, t, lo, hi;
      logic [63:0] p;
      int          r;
      rot  = ROT_INIT;
      a    = A_INIT;
      b    = B_INIT;
      w[0] = s;
      w[1] = s ^ W1_MASK;
      w[2] = s ^ W2_MASK;
      w[3] = s;
      for (r = 0; r < 4; r++) begin
         rot = {rot[30:0], rot[31]};
         mix = MIX_MASK ^ rot;
         xb  = b ^ w[r];
         xa  = a ^ w[r];
         t   = ((mix + xa) & T1_AND) | T1_OR;
         p   = {32'd0, t} * {32'd0, xb};
         lo  = p[31:0];
         hi  = p[63:32];
         b   = hi + lo + ((hi != 32'd0) ? 32'd1 : 32'd0);
         t   = ((mix + xb) & T2_AND) | T2_OR;
         p   = {32'd0, t} * {32'd0, xa};
         lo  = p[31:0];
         hi  = p[63:32];
         a   = lo + {hi[30:0], 1'b0};
      end
      return b ^ a;
   endfunction

   task automatic predict_cipher_byte(input logic [7:0] d, input logic is_last);
      logic [7:0]   kb;
      logic [7:0]   pb;
      cipher_word_type w;
      if (!sh_in_msg) begin
         sh_key_word = key_schedule(sh_use_default ? key_schedule(DEFAULT_BASE) : sh_key_seed);
         sh_byte_pos = 32'd0;
         sh_in_msg   = 1'b1;
      end
      kb = sh_key_word[sh_byte_pos[1:0]*8 +: 8];
      pb = sh_byte_pos[7:0] * POS_MULT;
      w.data    = d ^ kb ^ pb;
      w.is_last = is_last;
      pending_cipher_words.push_back(w);
      if (sh_byte_pos[7:0] == 8'hFF)
         sh_key_word = key_schedule(sh_key_word ^ sh_byte_pos);
      sh_byte_pos = sh_byte_pos + 32'd1;
      if (is_last)
         sh_in_msg = 1'b0;
   endtask

   task automatic send_byte(input logic [7:0] d, input logic is_last);
      int gap;
      gap = req_idle_en ? $urandom_range(0, 11) : 0;
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.data_in <= d;
      req_bus.last_in <= is_last;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      predict_cipher_byte(d, is_last);
   endtask

   task automatic send_message(input int len);
      int i;
      for (i = 0; i < len; i++)
         send_byte(8'($urandom_range(0, 255)), i == len - 1);
   endtask

   task automatic drain_results;
      req_bus.valid <= 1'b0;
      while (pending_cipher_words.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_KEY_SEED)
         sh_key_seed = value;
      else if (idx == CSR_USE_DEFAULT)
         sh_use_default = value[0];
      @(posedge clock);
   endtask

   // mode word carries random upper bits, only bit 0 counts
   task automatic set_key_mode(input logic use_default, input logic [31:0] seed);
      logic [31:0] mode_word;
      drain_results;
      mode_word    = $urandom();
      mode_word[0] = use_default;
      write_csr(CSR_KEY_SEED, seed);
      write_csr(CSR_USE_DEFAULT, mode_word);
   endtask

   task automatic report_bad(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("ERROR @%0t: %s", $time, msg);
   endtask

   // receiver with random stalls and an on-demand long hold
   initial begin : rsp_side
      cipher_word_type got;
      cipher_word_type want;
      int           stall;
      int           hold;
      logic         taken;
      while (reset) @(posedge clock);
      forever begin
         stall = rsp_idle_en ? $urandom_range(0, 11) : 0;
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         taken = 1'b0;
         while (!taken) begin
            @(posedge clock);
            if (rsp_bus.valid && rsp_bus.ready) begin
               taken = 1'b1;
            end else if (rsp_hold_len > 0) begin
               hold = rsp_hold_len;
               rsp_hold_len = 0;
               rsp_bus.ready <= 1'b0;
               repeat (hold) @(posedge clock);
               rsp_bus.ready <= 1'b1;
            end
         end
         got.data    = rsp_bus.data_out;
         got.is_last = rsp_bus.last_out;
         if (pending_cipher_words.size() == 0) begin
            report_bad($sformatf("unexpected word data=%02h last=%0b", got.data, got.is_last));
         end else begin
            want = pending_cipher_words.pop_front();
            if (got.data !== want.data || got.is_last !== want.is_last)
               report_bad($sformatf("data exp %02h act %02h, last exp %0b act %0b",
                                    want.data, got.data, want.is_last, got.is_last));
         end
      end
   end

   task automatic test_default_key_extremes;
      req_idle_en = 1'b0;
      rsp_idle_en = 1'b0;
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h01, 1'b1);
      send_byte(8'hFF, 1'b1);
      send_byte(8'hAA, 1'b0);
      send_byte(8'h55, 1'b1);
      drain_results;
   endtask

   task automatic test_seed_extremes;
      set_key_mode(1'b0, 32'h0000_0000);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      set_key_mode(1'b0, 32'hFFFF_FFFF);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h5A, 1'b1);
      drain_results;
   endtask

   // writes inside a message only apply from the next message on
   task automatic test_config_mid_message;
      set_key_mode(1'b1, 32'h0);
      send_message(0);
      send_byte(8'h12, 1'b0);
      send_byte(8'h34, 1'b0);
      send_byte(8'h56, 1'b0);
      drain_results;
      set_key_mode(1'b0, $urandom());
      send_byte(8'h78, 1'b0);
      send_byte(8'h9A, 1'b0);
      send_byte(8'hBC, 1'b1);
      send_byte(8'hDE, 1'b0);
      send_byte(8'hF0, 1'b1);
      drain_results;
   endtask

   // crosses two rekey points
   task automatic test_rekey_long_message;
      int i;
      set_key_mode(1'b0, $urandom());
      for (i = 0; i < 520; i++) begin
         if (i % 64 == 0) begin
            req_idle_en = 1'($urandom_range(0, 1));
            rsp_idle_en = 1'($urandom_range(0, 1));
         end
         send_byte(8'($urandom_range(0, 255)), i == 519);
      end
      drain_results;
   endtask

   task automatic test_backpressure;
      req_idle_en  = 1'b0;
      rsp_idle_en  = 1'b0;
      rsp_hold_len = 150;
      send_message(40);
      drain_results;
      send_message(5);
      drain_results;
   endtask

   task automatic test_random_messages;
      int phase;
      int sent;
      int len;
      for (phase = 0; phase < 6; phase++) begin
         drain_results;
         case (phase)
            0:       set_key_mode(1'b1, $urandom());
            1:       set_key_mode(1'b0, 32'h0000_0000);
            2:       set_key_mode(1'b0, 32'hFFFF_FFFF);
            5:       set_key_mode(1'b1, $urandom());
            default: set_key_mode(1'b0, $urandom());
         endcase
         req_idle_en = (phase % 3) != 1;
         rsp_idle_en = (phase % 3) != 2;
         sent = 0;
         while (sent < 40) begin
            len = ($urandom_range(0, 23) == 0) ? $urandom_range(250, 300)
                                                : $urandom_range(1, 24);
            if ($urandom_range(0, 3) == 0)
               drain_results;
            send_message(len);
            sent += len;
         end
      end
      drain_results;
   endtask

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_rekeying_byte_stream_cipher_core: FAIL");
      $finish;
   end

   initial begin : main_seq
      req_bus.valid   = 1'b0;
      req_bus.data_in = 8'h00;
      req_bus.last_in = 1'b0;
      rsp_bus.ready   = 1'b0;
      csr_we          = 1'b0;
      csr_index       = CSR_KEY_SEED;
      csr_wdata       = 32'd0;
      sh_key_seed     = 32'd0;
      sh_use_default  = 1'b1;
      sh_key_word     = 32'd0;
      sh_byte_pos     = 32'd0;
      sh_in_msg       = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_key_extremes;
      test_seed_extremes;
      test_config_mid_message;
      test_rekey_long_message;
      test_backpressure;
      test_random_messages;

      drain_results;
      repeat (100) @(posedge clock);
      if (mismatch_count == 0 && pending_cipher_words.size() == 0)
         $display("tb_rekeying_byte_stream_cipher_core: PASS");
      else
         $display("tb_rekeying_byte_stream_cipher_core: FAIL");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/rbsc_pkg.sv
rtl/core/rbsc_req_if.sv
rtl/core/rbsc_rsp_if.sv
rtl/core/rbsc_sched.sv
rtl/core/rekeying_byte_stream_cipher_core.sv
bench/tb_rekeying_byte_stream_cipher_core.sv
